/* rtl/lzw_pkg.sv */
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the LZW compressor core.
// ----------------------------------------------------------------------------
`default_nettype none
package lzw_pkg;

  localparam int DICT_SIZE   = 4096;
  localparam int STORE_DEPTH = 4096;
  localparam int CODE_W      = 12;
  localparam int CAP         = (DICT_SIZE > STORE_DEPTH) ? STORE_DEPTH : DICT_SIZE;
  localparam logic [CODE_W:0] CAP_CODE = (CODE_W + 1)'(CAP);

  typedef enum logic [1:0] {
    CMD_PRIME    = 2'd0,
    CMD_COMPRESS = 2'd1,
    CMD_FLUSH    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_ADD,
    ST_LINK
  } state_e;

  // One dictionary node: its last byte, first child and next sibling.
  typedef struct packed {
    logic [7:0]        last_byte;
    logic [CODE_W-1:0] child;
    logic [CODE_W-1:0] sibling;
  } node_t;

endpackage
`default_nettype wire

/* rtl/lzw_compressor_core.sv */
// ----------------------------------------------------------------------------
// lzw_compressor_core
// LZW compressor with an alphabet primed from the input and a trie dictionary.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; command_i and
// data_byte_i are sampled then. Prime requests give a new byte the next code,
// compress requests extend the current string, and flush emits the pending
// code. A result appears on code_o and status_o for one cycle with valid_o.
// The dictionary is a trie in one synchronous memory: each node holds its
// byte, first child and next sibling. A lookup walks the children of the
// current prefix, one memory read per child visited.
// Prime and flush requests are decided in ST_LOOK, as is a compress request
// that fails or starts a string. Otherwise a compress request visits ST_CMP
// once per child visited and goes to ST_ADD when no match is found; a new
// entry is then linked in through ST_LINK, unless the dictionary is full.
// The result strobe comes in the cycle after the deciding cycle.
// Reset clears the alphabet valid bits, the next code and the current string;
// the dictionary memory needs no clearing, since only written nodes are read.
// The receiver cannot stall; every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_compressor_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [1:0]                 command_i,
  input  wire logic [7:0]                 data_byte_i,
  output logic                            valid_o,
  output logic [lzw_pkg::CODE_W-1:0]      code_o,
  output logic                            status_o
);

  localparam int CW = lzw_pkg::CODE_W;

  lzw_pkg::state_e state_q, state_d;
  lzw_pkg::cmd_e   cmd_q, cmd_d;
  logic [7:0]      byte_q, byte_d;
  logic [CW:0]     next_q, next_d;
  logic [CW-1:0]   cur_q, cur_d;
  logic [CW-1:0]   single_q, single_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  lzw_pkg::node_t  pent_q, pent_d;
  logic            valid_q, valid_d;
  logic [CW-1:0]   code_q, code_d;
  logic            status_q, status_d;
  logic [255:0]    seen_q, seen_d;

  logic [CW-1:0]   alpha_mem [256];
  logic [CW-1:0]   alpha_rd_q;
  logic            alpha_we;

  lzw_pkg::node_t  dict_mem [lzw_pkg::STORE_DEPTH];
  lzw_pkg::node_t  dict_rd_q;
  logic [CW-1:0]   dict_ra;
  logic            dict_we;
  logic [CW-1:0]   dict_wa;
  lzw_pkg::node_t  dict_wd;

  logic            room;

  assign room = next_q < lzw_pkg::CAP_CODE;

  always_ff @(posedge clk_i) begin
    if (alpha_we) begin
      alpha_mem[byte_q] <= next_q[CW-1:0];
    end
    alpha_rd_q <= alpha_mem[data_byte_i];
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[dict_wa] <= dict_wd;
    end
    dict_rd_q <= dict_mem[dict_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzw_pkg::ST_IDLE;
      next_q   <= (CW + 1)'(1);
      cur_q    <= '0;
      seen_q   <= '0;
      valid_q  <= 1'b0;
      cmd_q    <= lzw_pkg::CMD_NONE;
    end else begin
      state_q  <= state_d;
      next_q   <= next_d;
      cur_q    <= cur_d;
      seen_q   <= seen_d;
      valid_q  <= valid_d;
      cmd_q    <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    single_q <= single_d;
    ptr_q    <= ptr_d;
    pent_q   <= pent_d;
    code_q   <= code_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    byte_d   = byte_q;
    next_d   = next_q;
    cur_d    = cur_q;
    single_d = single_q;
    ptr_d    = ptr_q;
    pent_d   = pent_q;
    seen_d   = seen_q;
    valid_d  = 1'b0;
    code_d   = code_q;
    status_d = status_q;
    alpha_we = 1'b0;
    dict_we  = 1'b0;
    dict_wa  = next_q[CW-1:0];
    dict_wd  = '{last_byte: byte_q, child: '0, sibling: '0};
    dict_ra  = cur_q;
    unique case (state_q)
      lzw_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d   = lzw_pkg::cmd_e'(command_i);
          byte_d  = data_byte_i;
          state_d = lzw_pkg::ST_LOOK;
        end
      end
      lzw_pkg::ST_LOOK: begin
        state_d = lzw_pkg::ST_IDLE;
        case (cmd_q)
          lzw_pkg::CMD_PRIME: begin
            if (!seen_q[byte_q] && room) begin
              alpha_we       = 1'b1;
              seen_d[byte_q] = 1'b1;
              dict_we        = 1'b1;
              next_d         = next_q + (CW + 1)'(1);
            end
          end
          lzw_pkg::CMD_COMPRESS: begin
            single_d = alpha_rd_q;
            pent_d   = dict_rd_q;
            if (!seen_q[byte_q]) begin
              valid_d  = 1'b1;
              code_d   = '0;
              status_d = 1'b1;
            end else if (cur_q == '0) begin
              cur_d = alpha_rd_q;
            end else if (dict_rd_q.child == '0) begin
              state_d = lzw_pkg::ST_ADD;
            end else begin
              dict_ra = dict_rd_q.child;
              ptr_d   = dict_rd_q.child;
              state_d = lzw_pkg::ST_CMP;
            end
          end
          lzw_pkg::CMD_FLUSH: begin
            if (cur_q != '0) begin
              valid_d  = 1'b1;
              code_d   = cur_q;
              status_d = 1'b0;
              cur_d    = '0;
            end
          end
          default: begin
          end
        endcase
      end
      lzw_pkg::ST_CMP: begin
        if (dict_rd_q.last_byte == byte_q) begin
          cur_d   = ptr_q;
          state_d = lzw_pkg::ST_IDLE;
        end else if (dict_rd_q.sibling != '0) begin
          dict_ra = dict_rd_q.sibling;
          ptr_d   = dict_rd_q.sibling;
        end else begin
          state_d = lzw_pkg::ST_ADD;
        end
      end
      lzw_pkg::ST_ADD: begin
        valid_d  = 1'b1;
        code_d   = cur_q;
        status_d = 1'b0;
        if (room) begin
          dict_we = 1'b1;
          dict_wd = '{last_byte: byte_q, child: '0, sibling: pent_q.child};
          state_d = lzw_pkg::ST_LINK;
        end else begin
          cur_d   = single_q;
          state_d = lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_LINK: begin
        dict_we = 1'b1;
        dict_wa = cur_q;
        dict_wd = '{last_byte: pent_q.last_byte, child: next_q[CW-1:0],
                    sibling: pent_q.sibling};
        next_d  = next_q + (CW + 1)'(1);
        cur_d   = single_q;
        state_d = lzw_pkg::ST_IDLE;
      end
      default: begin
        state_d = lzw_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o   = state_q != lzw_pkg::ST_IDLE;
  assign valid_o  = valid_q;
  assign code_o   = code_q;
  assign status_o = status_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> code_o == '0)
    else $error("error result carries a nonzero code");

  a_next_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= lzw_pkg::CAP_CODE)
    else $error("next code beyond capacity");

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without a request in progress");

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the LZW compressor core. Requests are driven with
// a start/busy handshake; a behavioral model of the dictionary predicts each
// emitted code, and every strobed result is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int CW = lzw_pkg::CODE_W;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [1:0]        command_i = lzw_pkg::CMD_PRIME;
  logic [7:0]        data_byte_i = 8'd0;
  logic              busy_o;
  logic              valid_o;
  logic [CW-1:0]     code_o;
  logic              status_o;

  lzw_compressor_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .data_byte_i,
    .valid_o, .code_o, .status_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [CW-1:0] code;
    logic          status;
  } emit_t;

  typedef struct {
    lzw_pkg::cmd_e     cmd;
    logic [7:0]        data;
    bit                has_typed;
    emit_t             typed;
  } row_t;

  logic [CW-1:0]     byte_code [256];
  logic [19:0]       trie_key [lzw_pkg::STORE_DEPTH];
  int unsigned       free_code;
  logic [CW-1:0]     cur_string;
  emit_t             pending_codes [$];
  int                fail_count = 0;
  int                code_count = 0;
  int                error_count = 0;
  int                sender_idle_pct = 0;
  int                max_code_seen = 0;

  task automatic report(input string what, input emit_t got, input emit_t exp);
    $display("ERROR %s: got code %0d status %0d, expected code %0d status %0d",
             what, got.code, got.status, exp.code, exp.status);
    fail_count++;
  endtask

  function automatic void lzw_init();
    foreach (byte_code[i]) byte_code[i] = '0;
    free_code  = 1;
    cur_string = '0;
  endfunction

  function automatic void lzw_add(input logic [CW-1:0] pre, input logic [7:0] b);
    if (free_code < lzw_pkg::CAP) begin
      trie_key[free_code] = {pre, b};
      free_code++;
    end
  endfunction

  // Returns 1 and fills res when the request emits a code.
  function automatic bit lzw_predict(input lzw_pkg::cmd_e cmd, input logic [7:0] b,
                                     output emit_t res);
    logic [CW-1:0] single;
    logic [CW-1:0] hit;
    res  = '0;
    hit  = '0;
    case (cmd)
      lzw_pkg::CMD_PRIME: begin
        if (byte_code[b] == '0 && free_code < lzw_pkg::CAP) begin
          byte_code[b] = CW'(free_code);
          lzw_add('0, b);
        end
        return 1'b0;
      end
      lzw_pkg::CMD_COMPRESS: begin
        single = byte_code[b];
        if (single == '0) begin
          res.status = 1'b1;
          return 1'b1;
        end
        if (cur_string == '0) begin
          cur_string = single;
          return 1'b0;
        end
        for (int c = 1; c < free_code; c++) begin
          if (trie_key[c] == {cur_string, b}) begin
            hit = CW'(c);
            break;
          end
        end
        if (hit != '0) begin
          cur_string = hit;
          return 1'b0;
        end
        lzw_add(cur_string, b);
        res.code   = cur_string;
        cur_string = single;
        return 1'b1;
      end
      lzw_pkg::CMD_FLUSH: begin
        if (cur_string == '0) return 1'b0;
        res.code   = cur_string;
        cur_string = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    emit_t got;
    emit_t exp;
    if (valid_o) begin
      got = '{code: code_o, status: status_o};
      if (pending_codes.size() == 0) begin
        report("unexpected result", got, '0);
      end else begin
        exp = pending_codes.pop_front();
        if (got !== exp) report("result mismatch", got, exp);
        if (got.status) error_count++;
        else code_count++;
        if (int'(got.code) > max_code_seen) max_code_seen = int'(got.code);
      end
    end
  end

  task automatic send(input lzw_pkg::cmd_e cmd, input logic [7:0] b, input bit has_typed,
                      input emit_t typed);
    emit_t res;
    bit    emits;
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start_i     <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (busy_o);
    emits = lzw_predict(cmd, b, res);
    if (has_typed && (!emits || res !== typed)) report("directed row", res, typed);
    if (emits) pending_codes.insert(pending_codes.size(), res);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    // A request that emits nothing may still be walking the trie.
    while ((pending_codes.size() != 0 || busy_o) && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2) @(posedge clk_i);
  endtask

  row_t directed [$];

  initial begin
    lzw_pkg::cmd_e cmd;
    logic [7:0]    b;
    int            pick;
    lzw_init();
    directed = '{
      '{lzw_pkg::CMD_COMPRESS, 8'h00, 1'b1, '{12'd0, 1'b1}},
      '{lzw_pkg::CMD_FLUSH,    8'hFF, 1'b0, '0},
      '{lzw_pkg::CMD_NONE,     8'hA5, 1'b0, '0},
      '{lzw_pkg::CMD_PRIME,    8'h00, 1'b0, '0},
      '{lzw_pkg::CMD_PRIME,    8'hFF, 1'b0, '0},
      '{lzw_pkg::CMD_PRIME,    8'h00, 1'b0, '0},
      '{lzw_pkg::CMD_PRIME,    8'h55, 1'b0, '0},
      '{lzw_pkg::CMD_COMPRESS, 8'hAA, 1'b1, '{12'd0, 1'b1}},
      '{lzw_pkg::CMD_COMPRESS, 8'h00, 1'b0, '0},
      '{lzw_pkg::CMD_COMPRESS, 8'hFF, 1'b1, '{12'd1, 1'b0}},
      '{lzw_pkg::CMD_COMPRESS, 8'h00, 1'b1, '{12'd2, 1'b0}},
      '{lzw_pkg::CMD_COMPRESS, 8'hFF, 1'b0, '0},
      '{lzw_pkg::CMD_COMPRESS, 8'h00, 1'b1, '{12'd4, 1'b0}},
      '{lzw_pkg::CMD_COMPRESS, 8'h55, 1'b0, '0},
      '{lzw_pkg::CMD_COMPRESS, 8'h55, 1'b0, '0},
      '{lzw_pkg::CMD_FLUSH,    8'h00, 1'b0, '0},
      '{lzw_pkg::CMD_FLUSH,    8'h00, 1'b0, '0},
      '{lzw_pkg::CMD_NONE,     8'h00, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send(directed[i].cmd, directed[i].data, directed[i].has_typed, directed[i].typed);
    end
    drain();

    // Mostly compress runs over a small alphabet so strings grow long; priming
    // and flushes are sprinkled in, and a few unprimed bytes raise errors.
    for (int n = 0; n < 900; n++) begin
      case ((n / 150) % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 78;
        2: sender_idle_pct = 13;
        default: sender_idle_pct = 0;
      endcase
      if (n % 150 == 0) drain();
      pick = $urandom_range(99);
      if (pick < 8) begin
        cmd = lzw_pkg::CMD_PRIME;
        b = 8'($urandom_range(255));
      end else if (pick < 12) begin
        cmd = lzw_pkg::CMD_FLUSH;
        b = 8'($urandom_range(255));
      end else if (pick < 14) begin
        cmd = lzw_pkg::CMD_NONE;
        b = 8'($urandom_range(255));
      end else if (pick < 18) begin
        cmd = lzw_pkg::CMD_COMPRESS;
        b = 8'($urandom_range(255));
      end else begin
        cmd = lzw_pkg::CMD_COMPRESS;
        b = 8'($urandom_range(7)) ^ 8'hF8 ^ (pick[0] ? 8'hFF : 8'h00);
      end
      send(cmd, b, 1'b0, '0);
    end
    send(lzw_pkg::CMD_FLUSH, 8'h00, 1'b0, '0);
    drain();

    $display("Covered prime, compress, flush and idle requests with sender gaps.");
    $display("Checked %0d codes (highest %0d) and %0d error results.",
             code_count, max_code_seen, error_count);
    if (fail_count == 0 && pending_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
